[rtl/core/balc_pkg.sv]
package balc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SUM_WIDTH_DEF  = 48;

    localparam int IO_W      = 32;
    localparam int BAND_W    = 31;
    localparam int GAIN_W    = 31;
    localparam int CHUNK_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [IO_W-1:0]   TARGET_POSITION_RST = 32'd65536;
    localparam logic [BAND_W-1:0] UPRIGHT_BAND_RST    = 31'd26214;
    localparam logic [BAND_W-1:0] BLEND_BAND_RST      = 31'd39322;
    localparam logic [BAND_W-1:0] POSITION_BAND_RST   = 31'd6554;
    localparam logic [GAIN_W-1:0] INNER_PROP_GAIN_RST = 31'd3276800;
    localparam logic [GAIN_W-1:0] INNER_INT_GAIN_RST  = 31'd32768;
    localparam logic [GAIN_W-1:0] POS_GAIN_FAR_RST    = 31'd3276800;
    localparam logic [GAIN_W-1:0] POS_GAIN_NEAR_RST   = 31'd19660800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_POSITION,
        CFG_UPRIGHT_BAND,
        CFG_BLEND_BAND,
        CFG_POSITION_BAND,
        CFG_INNER_PROP_GAIN,
        CFG_INNER_INT_GAIN,
        CFG_POS_GAIN_FAR,
        CFG_POS_GAIN_NEAR
    } balc_cfg_idx_t;

    typedef struct packed {
        logic [IO_W-1:0]   target_position;
        logic [BAND_W-1:0] upright_band;
        logic [BAND_W-1:0] blend_band;
        logic [BAND_W-1:0] position_band;
        logic [GAIN_W-1:0] inner_prop_gain;
        logic [GAIN_W-1:0] inner_int_gain;
        logic [GAIN_W-1:0] pos_gain_far;
        logic [GAIN_W-1:0] pos_gain_near;
    } balc_cfg_t;

    typedef enum logic [2:0] {
        OP_UP_P,
        OP_UP_D,
        OP_IN_P,
        OP_IN_I,
        OP_POS_P,
        OP_POS_D,
        OP_MIX_IN,
        OP_MIX_POS
    } balc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEL,
        ST_MUL,
        ST_COMB,
        ST_OUT
    } balc_state_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_ABS,
        MUL_MAC,
        MUL_FIN
    } balc_mul_state_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] gain;
    } balc_mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } balc_mul_stat_t;

endpackage

[rtl/core/balc_cfg.sv]
module balc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [balc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [balc_pkg::IO_W-1:0]      cfg_data,
    output balc_pkg::balc_cfg_t           regs
);
    import balc_pkg::*;

    balc_cfg_t regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.target_position <= TARGET_POSITION_RST;
            regs_reg.upright_band    <= UPRIGHT_BAND_RST;
            regs_reg.blend_band      <= BLEND_BAND_RST;
            regs_reg.position_band   <= POSITION_BAND_RST;
            regs_reg.inner_prop_gain <= INNER_PROP_GAIN_RST;
            regs_reg.inner_int_gain  <= INNER_INT_GAIN_RST;
            regs_reg.pos_gain_far    <= POS_GAIN_FAR_RST;
            regs_reg.pos_gain_near   <= POS_GAIN_NEAR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_POSITION: regs_reg.target_position <= cfg_data;
                CFG_UPRIGHT_BAND:    regs_reg.upright_band    <= cfg_data[BAND_W-1:0];
                CFG_BLEND_BAND:      regs_reg.blend_band      <= cfg_data[BAND_W-1:0];
                CFG_POSITION_BAND:   regs_reg.position_band   <= cfg_data[BAND_W-1:0];
                CFG_INNER_PROP_GAIN: regs_reg.inner_prop_gain <= cfg_data[GAIN_W-1:0];
                CFG_INNER_INT_GAIN:  regs_reg.inner_int_gain  <= cfg_data[GAIN_W-1:0];
                CFG_POS_GAIN_FAR:    regs_reg.pos_gain_far    <= cfg_data[GAIN_W-1:0];
                CFG_POS_GAIN_NEAR:   regs_reg.pos_gain_near   <= cfg_data[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

[rtl/core/balc_mulq.sv]
module balc_mulq #(
    parameter int OP_W       = balc_pkg::SUM_WIDTH_DEF,
    parameter int DATA_WIDTH = balc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = balc_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  balc_pkg::balc_mul_req_t      req,
    input  logic signed [OP_W-1:0]       opnd,
    output balc_pkg::balc_mul_stat_t     stat,
    output logic signed [DATA_WIDTH-1:0] result
);
    import balc_pkg::*;

    localparam int NCHUNK = (OP_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MAG_W  = NCHUNK * CHUNK_W;
    localparam int ACC_W  = MAG_W + GAIN_W;
    localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] LIM_POS = ACC_W'({(DATA_WIDTH-1){1'b1}});
    localparam logic [ACC_W-1:0] LIM_NEG = LIM_POS + ACC_W'(1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(NCHUNK - 1);

    balc_mul_state_t state_reg;
    balc_mul_state_t state_next;

    logic signed [OP_W-1:0]       opnd_reg;
    logic [GAIN_W-1:0]            gain_reg;
    logic                         neg_reg;
    logic [MAG_W-1:0]             mag_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] result_reg;

    logic [OP_W-1:0]              mag_raw;
    logic [CHUNK_W-1:0]           chunk;
    logic [CHUNK_W+GAIN_W-1:0]    part;
    logic                         last_chunk;
    logic [ACC_W-1:0]             acc_sum;
    logic [ACC_W-1:0]             quot;
    logic [ACC_W-1:0]             lim;
    logic [ACC_W-1:0]             qsat;
    logic [DATA_WIDTH-1:0]        qlow;

    // The magnitude is consumed one chunk per cycle, most significant first.
    always_comb
    begin
        mag_raw    = opnd_reg[OP_W-1] ? OP_W'(-opnd_reg) : opnd_reg;
        chunk      = mag_reg[cnt_reg*CHUNK_W +: CHUNK_W];
        part       = chunk * gain_reg;
        last_chunk = (cnt_reg == '0);
        acc_sum    = (acc_reg << CHUNK_W) + ACC_W'(part) + (last_chunk ? ROUND_C : '0);
        quot       = acc_reg >> FRAC_BITS;
        lim        = neg_reg ? LIM_NEG : LIM_POS;
        qsat       = (quot > lim) ? lim : quot;
        qlow       = qsat[DATA_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MUL_IDLE:
            begin
                if (req.start)
                begin
                    state_next = MUL_ABS;
                end
            end
            MUL_ABS:
            begin
                state_next = MUL_MAC;
            end
            MUL_MAC:
            begin
                if (last_chunk)
                begin
                    state_next = MUL_FIN;
                end
            end
            MUL_FIN:
            begin
                state_next = MUL_IDLE;
            end
            default:
            begin
                state_next = MUL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.busy = (state_reg != MUL_IDLE);
        stat.done = done_reg;
        result    = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MUL_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MUL_IDLE && req.start)
        begin
            opnd_reg <= opnd;
            gain_reg <= req.gain;
        end
        if (state_reg == MUL_ABS)
        begin
            neg_reg <= opnd_reg[OP_W-1];
            mag_reg <= MAG_W'(mag_raw);
            acc_reg <= '0;
            cnt_reg <= CNT_TOP;
        end
        if (state_reg == MUL_MAC)
        begin
            acc_reg <= acc_sum;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (state_reg == MUL_FIN)
        begin
            result_reg <= $signed(neg_reg ? -qlow : qlow);
        end
    end

endmodule

[rtl/core/balance_cascade_pid_core.sv]
// Cascaded balance controller: upright PD, inner PI with integrator, position PD, blend.
// Each transaction runs the eight products in turn through the single 16 x 31 multiplier,
// which takes N 16-bit operand chunks per product, N = ceil(max(DATA_WIDTH, SUM_WIDTH) / 16).
// A new transaction is accepted only after the previous result has been loaded for output.
// Reset (asynchronous, active low) clears the sequencer, history and integrator and loads defaults.
module balance_cascade_pid_core #(
    parameter int DATA_WIDTH = balc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = balc_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH  = balc_pkg::SUM_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [balc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [balc_pkg::IO_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [balc_pkg::IO_W-1:0] tilt_angle,
    input  logic signed [balc_pkg::IO_W-1:0] position,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [balc_pkg::IO_W-1:0] drive_command
);
    import balc_pkg::*;

    localparam int OP_W   = (SUM_WIDTH > DATA_WIDTH) ? SUM_WIDTH : DATA_WIDTH;
    localparam int WIDE_W = ((OP_W > IO_W) ? OP_W : IO_W) + 1;
    localparam int CMP_W  = (DATA_WIDTH - 1 > BAND_W) ? DATA_WIDTH - 1 : BAND_W;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    localparam logic [GAIN_W-1:0] K_UP_P_WIDE   = GAIN_W'(15 * ONE_Q);
    localparam logic [GAIN_W-1:0] K_UP_D_WIDE   = GAIN_W'(ONE_Q >> 1);
    localparam logic [GAIN_W-1:0] K_UP_P_NARROW = GAIN_W'(25 * ONE_Q);
    localparam logic [GAIN_W-1:0] K_UP_D_NARROW = GAIN_W'(ONE_Q);
    localparam logic [GAIN_W-1:0] K_POS_D       = GAIN_W'((ONE_Q + 5) / 10);
    localparam logic [GAIN_W-1:0] W_HI_INNER    = GAIN_W'((ONE_Q + 5) / 10);
    localparam logic [GAIN_W-1:0] W_HI_POS      = GAIN_W'((9 * ONE_Q + 5) / 10);
    localparam logic [GAIN_W-1:0] W_LO_INNER    = GAIN_W'((ONE_Q + 5000) / 10000);
    localparam logic [GAIN_W-1:0] W_LO_POS      = GAIN_W'((9999 * ONE_Q + 5000) / 10000);

    function automatic logic signed [WIDE_W-1:0] sat_w(
        input logic signed [WIDE_W-1:0] v,
        input int                       w
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] r;
        hi = $signed((WIDE_W'(1) << (w - 1)) - WIDE_W'(1));
        lo = ~hi;
        if (v > hi)
        begin
            r = hi;
        end
        else if (v < lo)
        begin
            r = lo;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_d(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        t = sat_w(v, DATA_WIDTH);
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] sat_s(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        t = sat_w(v, SUM_WIDTH);
        return t[SUM_WIDTH-1:0];
    endfunction

    function automatic logic signed [IO_W-1:0] sat_o(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        t = sat_w(v, IO_W);
        return t[IO_W-1:0];
    endfunction

    balc_cfg_t      cfg;
    balc_mul_req_t  mul_req;
    balc_mul_stat_t mul_stat;
    logic signed [DATA_WIDTH-1:0] mul_result;

    balc_state_t state_reg;
    balc_state_t state_next;
    balc_op_t    op_reg;
    balc_op_t    op_next;

    logic signed [DATA_WIDTH-1:0] a_reg;
    logic signed [DATA_WIDTH-1:0] p_reg;
    logic signed [DATA_WIDTH-1:0] tgt_reg;
    logic signed [DATA_WIDTH-1:0] prev_angle_reg;
    logic signed [DATA_WIDTH-1:0] prev_pos_reg;
    logic signed [SUM_WIDTH-1:0]  sum_reg;
    logic signed [DATA_WIDTH-1:0] ie_reg;
    logic signed [DATA_WIDTH-1:0] up_reg;
    logic signed [DATA_WIDTH-1:0] inner_reg;
    logic signed [DATA_WIDTH-1:0] pos_reg;
    logic signed [DATA_WIDTH-1:0] cmd_reg;
    logic signed [DATA_WIDTH-1:0] t0_reg;
    logic signed [OP_W-1:0]       opnd_reg;
    logic                         narrow_reg;
    logic                         blend_reg;
    logic                         out_valid_reg;
    logic signed [IO_W-1:0]       drive_reg;

    logic                         accept;
    logic                         load_out;
    logic signed [WIDE_W-1:0]     add_x;
    logic signed [WIDE_W-1:0]     add_y;
    logic signed [WIDE_W-1:0]     add_wide;
    logic signed [DATA_WIDTH-1:0] add_d;
    logic signed [SUM_WIDTH-1:0]  add_s;
    logic signed [DATA_WIDTH-1:0] opnd_d;
    logic [DATA_WIDTH-1:0]        neg_d;
    logic [DATA_WIDTH-2:0]        mag_d;
    logic [CMP_W-1:0]             mag_c;
    logic                         lt_up;
    logic                         gt_blend;
    logic                         lt_pos;
    logic [GAIN_W-1:0]            gain_sel;

    balc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    balc_mulq #(
        .OP_W       (OP_W),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mulq (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .opnd   (opnd_reg),
        .stat   (mul_stat),
        .result (mul_result)
    );

    // Shared saturating adder: operand preparation and product combination.
    always_comb
    begin
        add_x = '0;
        add_y = '0;
        if (state_reg == ST_COMB)
        begin
            add_x = WIDE_W'(t0_reg);
            add_y = WIDE_W'(mul_result);
        end
        else
        begin
            case (op_reg)
                OP_UP_P:
                begin
                    add_x = WIDE_W'(a_reg);
                end
                OP_UP_D:
                begin
                    add_x = WIDE_W'(a_reg);
                    add_y = -WIDE_W'(prev_angle_reg);
                end
                OP_IN_P:
                begin
                    add_x = WIDE_W'(up_reg);
                    add_y = -WIDE_W'(a_reg);
                end
                OP_IN_I:
                begin
                    add_x = WIDE_W'(sum_reg);
                    add_y = WIDE_W'(ie_reg);
                end
                OP_POS_P:
                begin
                    add_x = WIDE_W'(tgt_reg);
                    add_y = -WIDE_W'(p_reg);
                end
                OP_POS_D:
                begin
                    add_x = WIDE_W'(p_reg);
                    add_y = -WIDE_W'(prev_pos_reg);
                end
                OP_MIX_IN:
                begin
                    add_x = WIDE_W'(inner_reg);
                end
                OP_MIX_POS:
                begin
                    add_x = WIDE_W'(pos_reg);
                end
                default:
                begin
                    add_x = '0;
                end
            endcase
        end
        add_wide = add_x + add_y;
        add_d    = sat_d(add_wide);
        add_s    = sat_s(add_wide);
    end

    // The magnitude used for band compares saturates the most negative value.
    always_comb
    begin
        opnd_d   = opnd_reg[DATA_WIDTH-1:0];
        neg_d    = -opnd_d;
        if (!opnd_d[DATA_WIDTH-1])
        begin
            mag_d = opnd_d[DATA_WIDTH-2:0];
        end
        else if (neg_d[DATA_WIDTH-1])
        begin
            mag_d = '1;
        end
        else
        begin
            mag_d = neg_d[DATA_WIDTH-2:0];
        end
        mag_c    = CMP_W'(mag_d);
        lt_up    = (mag_c < CMP_W'(cfg.upright_band));
        gt_blend = (mag_c > CMP_W'(cfg.blend_band));
        lt_pos   = (mag_c < CMP_W'(cfg.position_band));
        case (op_reg)
            OP_UP_P:    gain_sel = lt_up ? K_UP_P_NARROW : K_UP_P_WIDE;
            OP_UP_D:    gain_sel = narrow_reg ? K_UP_D_NARROW : K_UP_D_WIDE;
            OP_IN_P:    gain_sel = cfg.inner_prop_gain;
            OP_IN_I:    gain_sel = cfg.inner_int_gain;
            OP_POS_P:   gain_sel = lt_pos ? cfg.pos_gain_near : cfg.pos_gain_far;
            OP_POS_D:   gain_sel = K_POS_D;
            OP_MIX_IN:  gain_sel = blend_reg ? W_HI_INNER : W_LO_INNER;
            OP_MIX_POS: gain_sel = blend_reg ? W_HI_POS : W_LO_POS;
            default:    gain_sel = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                    op_next    = OP_UP_P;
                end
            end
            ST_PREP:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_COMB;
                end
            end
            ST_COMB:
            begin
                if (op_reg == OP_MIX_POS)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PREP;
                    op_next    = balc_op_t'(op_reg + 3'd1);
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cfg_ready     = 1'b1;
        accept        = in_valid && (state_reg == ST_IDLE);
        load_out      = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
        mul_req.start = (state_reg == ST_SEL);
        mul_req.gain  = gain_sel;
        out_valid     = out_valid_reg;
        drive_command = drive_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_UP_P;
            out_valid_reg  <= 1'b0;
            prev_angle_reg <= '0;
            prev_pos_reg   <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                prev_angle_reg <= a_reg;
                prev_pos_reg   <= p_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_PREP && op_reg == OP_IN_I)
            begin
                sum_reg <= add_s;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg   <= sat_d(WIDE_W'(tilt_angle));
            p_reg   <= sat_d(WIDE_W'(position));
            tgt_reg <= sat_d(WIDE_W'($signed(cfg.target_position)));
        end
        if (state_reg == ST_PREP)
        begin
            if (op_reg == OP_IN_I)
            begin
                opnd_reg <= OP_W'(add_s);
            end
            else
            begin
                opnd_reg <= OP_W'(add_d);
            end
            if (op_reg == OP_IN_P)
            begin
                ie_reg <= add_d;
            end
        end
        if (state_reg == ST_SEL && op_reg == OP_UP_P)
        begin
            narrow_reg <= lt_up;
            blend_reg  <= gt_blend;
        end
        if (state_reg == ST_COMB)
        begin
            case (op_reg)
                OP_UP_P:    t0_reg    <= mul_result;
                OP_UP_D:    up_reg    <= add_d;
                OP_IN_P:    t0_reg    <= mul_result;
                OP_IN_I:    inner_reg <= add_d;
                OP_POS_P:   t0_reg    <= mul_result;
                OP_POS_D:   pos_reg   <= add_d;
                OP_MIX_IN:  t0_reg    <= mul_result;
                OP_MIX_POS: cmd_reg   <= add_d;
                default:    t0_reg    <= mul_result;
            endcase
        end
        if (load_out)
        begin
            drive_reg <= sat_o(WIDE_W'(cmd_reg));
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_stat.busy)
        else $error("Multiplier was started while still busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mul_stat.busy)
        else $error("Block offered to accept a transaction while the multiplier was busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> state_reg == ST_MUL)
        else $error("Multiplier finished while the sequencer was not waiting for it.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("Result appeared without passing through the output state.");

endmodule
